[hw/rtl/bpit_pkg.sv]
package bpit_pkg;

  localparam int CW  = 16;                 // coordinate field width
  localparam int DW  = CW + 1;             // edge vector width
  localparam int PW  = 2 * DW;             // product width
  localparam int XW  = PW + 1;             // cross product width
  localparam int MW  = XW;                 // magnitude width
  localparam int WFB = 14;                 // weight fraction bits
  localparam int WW  = 18;                 // weight field width
  localparam int TW  = 10;                 // tolerance width
  localparam int QB  = WW + 3;             // quotient bits kept before rounding
  localparam int LW  = QB - WFB - 1;       // numerator bits shifted in by the divider
  localparam int RW  = QB + 2;             // signed rounded weight width
  localparam int QD  = 4;                  // queue depth
  localparam int QAW = $clog2(QD);

  localparam logic [TW-1:0] TOL_RESET = TW'(1);

  typedef struct packed {
    logic                 degen;
    logic signed [XW-1:0] den;
    logic signed [XW-1:0] nu;
    logic signed [XW-1:0] nv;
  } item_t;

  typedef struct packed {
    logic          degen;
    logic          neg_u;
    logic          neg_v;
    logic          ovf_u;
    logic          ovf_v;
    logic [MW-1:0] ad;
    logic [MW-1:0] ru;
    logic [MW-1:0] rv;
    logic [LW-1:0] lo_u;
    logic [LW-1:0] lo_v;
    logic [QB-1:0] qu;
    logic [QB-1:0] qv;
  } bk_t;

endpackage

[hw/rtl/barycentric_point_in_triangle_top.sv]
// Channel   Handshake            Payload
// in_       in_valid / in_stall  point_x/y, corner_a/b/c_x/y (signed Q4.12)
// out_      out_valid/out_stall  weight_c, weight_b (signed Q4.14), inside_res, degenerate
// cfg_      cfg_wr_en            cfg_wr_data: edge tolerance, 10 bits
// One request per cycle sustained while out_stall stays low.
// Latency is set by the 21-stage restoring divider, one quotient bit per stage.
// Front: edge vectors, products, cross products; a 4-entry queue feeds the divider.
// Synchronous active-low reset empties the pipeline and sets the tolerance to 1.
// Stalls propagate back through the stages combinationally; empty stages keep accepting.
module barycentric_point_in_triangle_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [bpit_pkg::CW-1:0] in_point_x,
  input  logic signed [bpit_pkg::CW-1:0] in_point_y,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_a_x,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_a_y,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_b_x,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_b_y,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_c_x,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_c_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [bpit_pkg::WW-1:0] out_weight_c,
  output logic signed [bpit_pkg::WW-1:0] out_weight_b,
  output logic                           out_inside_res,
  output logic                           out_degenerate,
  input  logic                           cfg_wr_en,
  input  logic [bpit_pkg::TW-1:0]        cfg_wr_data
);
  import bpit_pkg::*;

  logic  push, pop, q_full, q_empty;
  item_t push_item, pop_item;

  bpit_front u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_point_x, .in_point_y, .in_corner_a_x, .in_corner_a_y,
    .in_corner_b_x, .in_corner_b_y, .in_corner_c_x, .in_corner_c_y,
    .push, .push_item, .q_full
  );

  bpit_queue u_queue (
    .clk, .rst_n, .push, .push_item, .q_full, .pop, .q_empty, .pop_item
  );

  bpit_back u_back (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .q_empty, .pop_item, .pop,
    .out_valid, .out_stall, .out_weight_c, .out_weight_b,
    .out_inside_res, .out_degenerate
  );

endmodule

[hw/rtl/bpit_front.sv]
module bpit_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [bpit_pkg::CW-1:0] in_point_x,
  input  logic signed [bpit_pkg::CW-1:0] in_point_y,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_a_x,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_a_y,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_b_x,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_b_y,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_c_x,
  input  logic signed [bpit_pkg::CW-1:0] in_corner_c_y,
  output logic                         push,
  output bpit_pkg::item_t              push_item,
  input  logic                         q_full
);
  import bpit_pkg::*;

  logic [2:0] vld_r;
  logic [2:0] rdy;

  logic signed [DW-1:0] e0x_r, e0y_r, e1x_r, e1y_r, e2x_r, e2y_r;
  logic signed [PW-1:0] pd1_r, pd2_r, pu1_r, pu2_r, pv1_r, pv2_r;
  item_t                item_r;
  logic signed [XW-1:0] den_nxt;

  assign rdy[2]   = !vld_r[2] || !q_full;
  assign rdy[1]   = !vld_r[1] || rdy[2];
  assign rdy[0]   = !vld_r[0] || rdy[1];
  assign in_stall = !rdy[0];
  assign push      = vld_r[2] && !q_full;
  assign push_item = item_r;
  assign den_nxt   = XW'(pd1_r) - XW'(pd2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
    end
    if (rdy[0] && in_valid) begin
      e0x_r <= DW'(in_corner_c_x) - DW'(in_corner_a_x);
      e0y_r <= DW'(in_corner_c_y) - DW'(in_corner_a_y);
      e1x_r <= DW'(in_corner_b_x) - DW'(in_corner_a_x);
      e1y_r <= DW'(in_corner_b_y) - DW'(in_corner_a_y);
      e2x_r <= DW'(in_point_x) - DW'(in_corner_a_x);
      e2y_r <= DW'(in_point_y) - DW'(in_corner_a_y);
    end
    if (rdy[1] && vld_r[0]) begin
      pd1_r <= PW'(e1x_r) * PW'(e0y_r);
      pd2_r <= PW'(e1y_r) * PW'(e0x_r);
      pu1_r <= PW'(e1x_r) * PW'(e2y_r);
      pu2_r <= PW'(e1y_r) * PW'(e2x_r);
      pv1_r <= PW'(e2x_r) * PW'(e0y_r);
      pv2_r <= PW'(e2y_r) * PW'(e0x_r);
    end
    if (rdy[2] && vld_r[1]) begin
      item_r.den   <= den_nxt;
      item_r.degen <= (den_nxt == '0);
      item_r.nu    <= XW'(pu1_r) - XW'(pu2_r);
      item_r.nv    <= XW'(pv1_r) - XW'(pv2_r);
    end
  end

endmodule

[hw/rtl/bpit_queue.sv]
module bpit_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bpit_pkg::item_t push_item,
  output logic            q_full,
  input  logic            pop,
  output logic            q_empty,
  output bpit_pkg::item_t pop_item
);
  import bpit_pkg::*;

  item_t          mem_r [QD];
  logic [QAW:0]   wp_r, rp_r;

  assign q_empty  = (wp_r == rp_r);
  assign q_full   = (wp_r[QAW-1:0] == rp_r[QAW-1:0]) && (wp_r[QAW] != rp_r[QAW]);
  assign pop_item = mem_r[rp_r[QAW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
    end
    if (push) mem_r[wp_r[QAW-1:0]] <= push_item;
  end

endmodule

[hw/rtl/bpit_back.sv]
module bpit_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bpit_pkg::TW-1:0]        cfg_wr_data,
  input  logic                           q_empty,
  input  bpit_pkg::item_t                pop_item,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [bpit_pkg::WW-1:0] out_weight_c,
  output logic signed [bpit_pkg::WW-1:0] out_weight_b,
  output logic                           out_inside_res,
  output logic                           out_degenerate
);
  import bpit_pkg::*;

  localparam logic signed [RW+1:0] ONE   = (RW+2)'(1) <<< WFB;
  localparam logic signed [RW-1:0] W_MAX = RW'((1 << (WW-1)) - 1);
  localparam logic signed [RW-1:0] W_MIN = -RW'(1 << (WW-1));
  localparam logic [QB-1:0]        CAP   = {2'b01, {(QB-2){1'b0}}};

  logic [TW-1:0]  tol_r;
  logic [QB:0]    vld_r;
  bk_t            st_r [QB+1];
  logic [QB:0]    rdy;
  logic           ovld_r;
  bk_t            init_nxt;
  logic [MW-1:0]  an_u, an_v;

  function automatic bk_t div_step(bk_t s);
    bk_t         o;
    logic [MW:0] su, sv;
    logic        gu, gv;
    o  = s;
    su = {s.ru, s.lo_u[LW-1]};
    sv = {s.rv, s.lo_v[LW-1]};
    gu = su >= {1'b0, s.ad};
    gv = sv >= {1'b0, s.ad};
    o.ru   = gu ? MW'(su - {1'b0, s.ad}) : MW'(su);
    o.rv   = gv ? MW'(sv - {1'b0, s.ad}) : MW'(sv);
    o.qu   = {s.qu[QB-2:0], gu};
    o.qv   = {s.qv[QB-2:0], gv};
    o.lo_u = {s.lo_u[LW-2:0], 1'b0};
    o.lo_v = {s.lo_v[LW-2:0], 1'b0};
    return o;
  endfunction

  function automatic logic signed [RW-1:0] rounded(logic [QB-1:0] q, logic ovf, logic neg);
    logic [QB:0]   sum;
    logic [QB-1:0] mag;
    sum = {1'b0, q} + 1'b1;
    mag = ovf ? CAP : sum[QB:1];
    return neg ? -RW'(mag) : RW'(mag);
  endfunction

  function automatic logic signed [WW-1:0] sat(logic signed [RW-1:0] w);
    if (w > W_MAX)      return WW'(W_MAX);
    else if (w < W_MIN) return WW'(W_MIN);
    else                return WW'(w);
  endfunction

  always_comb begin
    an_u = MW'(pop_item.nu[XW-1] ? -pop_item.nu : pop_item.nu);
    an_v = MW'(pop_item.nv[XW-1] ? -pop_item.nv : pop_item.nv);
    init_nxt       = '0;
    init_nxt.degen = pop_item.degen;
    init_nxt.ad    = MW'(pop_item.den[XW-1] ? -pop_item.den : pop_item.den);
    init_nxt.neg_u = pop_item.nu[XW-1] ^ pop_item.den[XW-1];
    init_nxt.neg_v = pop_item.nv[XW-1] ^ pop_item.den[XW-1];
    init_nxt.ovf_u = {{LW{1'b0}}, an_u} >= {init_nxt.ad, {LW{1'b0}}};
    init_nxt.ovf_v = {{LW{1'b0}}, an_v} >= {init_nxt.ad, {LW{1'b0}}};
    init_nxt.ru    = an_u >> LW;
    init_nxt.rv    = an_v >> LW;
    init_nxt.lo_u  = an_u[LW-1:0];
    init_nxt.lo_v  = an_v[LW-1:0];
  end

  always_comb begin
    rdy[QB] = !vld_r[QB] || !ovld_r || !out_stall;
    for (int k = QB - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign pop       = rdy[0] && !q_empty;
  assign out_valid = ovld_r;

  logic signed [RW-1:0]   u_w, v_w;
  logic signed [RW+1:0]   uv_sum, tol_s;
  assign u_w    = rounded(st_r[QB].qu, st_r[QB].ovf_u, st_r[QB].neg_u);
  assign v_w    = rounded(st_r[QB].qv, st_r[QB].ovf_v, st_r[QB].neg_v);
  assign uv_sum = (RW+2)'(u_w) + (RW+2)'(v_w);
  assign tol_s  = (RW+2)'(tol_r);

  logic orq;
  assign orq = !ovld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= TOL_RESET;
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) tol_r <= cfg_wr_data;
      if (rdy[0]) vld_r[0] <= !q_empty;
      for (int k = 1; k <= QB; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
      if (orq) ovld_r <= vld_r[QB];
    end
    if (pop) st_r[0] <= init_nxt;
    for (int k = 1; k <= QB; k++) begin
      if (rdy[k] && vld_r[k-1]) st_r[k] <= div_step(st_r[k-1]);
    end
    if (orq && vld_r[QB]) begin
      if (st_r[QB].degen) begin
        out_weight_c   <= '0;
        out_weight_b   <= '0;
        out_inside_res <= 1'b0;
        out_degenerate <= 1'b1;
      end else begin
        out_weight_c   <= sat(u_w);
        out_weight_b   <= sat(v_w);
        out_inside_res <= ((RW+2)'(u_w) >= -tol_s) && ((RW+2)'(v_w) >= -tol_s)
                          && (uv_sum <= ONE + tol_s);
        out_degenerate <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/bpit_checker.sv]
module bpit_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [bpit_pkg::WW-1:0] out_weight_c,
  input logic signed [bpit_pkg::WW-1:0] out_weight_b,
  input logic                           out_inside_res,
  input logic                           out_degenerate
);
  import bpit_pkg::*;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_inside_res && out_weight_c == '0
      && out_weight_b == '0)
    else $error("degenerate request with non-zero result");

  a_inside_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |-> out_weight_c >= -WW'(1023) && out_weight_b >= -WW'(1023)
      && out_weight_c <= WW'(18430) && out_weight_b <= WW'(18430))
    else $error("inside flag with weight out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_weight_c) && $stable(out_weight_b))
    else $error("stalled request changed");

endmodule

bind barycentric_point_in_triangle_top bpit_checker u_bpit_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_weight_c, .out_weight_b,
  .out_inside_res, .out_degenerate
);

[sim/tb_barycentric_point_in_triangle_top.sv]
module tb_barycentric_point_in_triangle_top;

  localparam int CW        = bpit_pkg::CW;
  localparam int WW        = bpit_pkg::WW;
  localparam int TW        = bpit_pkg::TW;
  localparam int FRAC      = bpit_pkg::WFB;
  localparam int GAP_MAX   = 17;
  localparam int DRAIN     = 40;
  localparam int WDOG_MAX  = 3000;

  typedef struct packed {
    logic signed [CW-1:0] px, py, ax, ay, bx, by, cx, cy;
  } tri_query_t;

  typedef struct packed {
    logic signed [WW-1:0] wc;
    logic signed [WW-1:0] wb;
    logic                 in_tri;
    logic                 degen;
  } bary_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] in_point_x = '0, in_point_y = '0;
  logic signed [CW-1:0] in_corner_a_x = '0, in_corner_a_y = '0;
  logic signed [CW-1:0] in_corner_b_x = '0, in_corner_b_y = '0;
  logic signed [CW-1:0] in_corner_c_x = '0, in_corner_c_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [WW-1:0] out_weight_c, out_weight_b;
  logic                 out_inside_res, out_degenerate;
  logic                 cfg_wr_en = 1'b0;
  logic [TW-1:0]        cfg_wr_data = '0;

  tri_query_t pending_q[$];
  bary_res_t  expected_wts[$];
  tri_query_t cur_query;
  logic [TW-1:0] tol_copy = TW'(1);
  int  errors = 0;
  int  in_gap = 0;
  int  out_wait = 0;
  int  gdraw, sdraw;
  int  wdog = 0;
  bit  quiet = 1'b0;
  bit  hold = 1'b0;

  barycentric_point_in_triangle_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_corner_a_x(in_corner_a_x), .in_corner_a_y(in_corner_a_y),
    .in_corner_b_x(in_corner_b_x), .in_corner_b_y(in_corner_b_y),
    .in_corner_c_x(in_corner_c_x), .in_corner_c_y(in_corner_c_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_weight_c(out_weight_c), .out_weight_b(out_weight_b),
    .out_inside_res(out_inside_res), .out_degenerate(out_degenerate),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  function automatic longint round_quot(longint num, longint den);
    longint an, ad, mag;
    bit neg;
    neg = (num < 0) != (den < 0);
    an  = num < 0 ? -num : num;
    ad  = den < 0 ? -den : den;
    mag = ((an <<< FRAC) + ad / 2) / ad;
    return neg ? -mag : mag;
  endfunction

  function automatic logic signed [WW-1:0] clamp_weight(longint w);
    if (w > 131071) w = 131071;
    if (w < -131072) w = -131072;
    return w[WW-1:0];
  endfunction

  function automatic bary_res_t barycentric_weights(tri_query_t q, logic [TW-1:0] tol);
    longint e0x, e0y, e1x, e1y, e2x, e2y, den, nu, nv, u, v, t;
    bary_res_t r;
    e0x = longint'(q.cx) - q.ax;  e0y = longint'(q.cy) - q.ay;
    e1x = longint'(q.bx) - q.ax;  e1y = longint'(q.by) - q.ay;
    e2x = longint'(q.px) - q.ax;  e2y = longint'(q.py) - q.ay;
    den = e1x * e0y - e1y * e0x;
    nu  = e1x * e2y - e1y * e2x;
    nv  = e2x * e0y - e2y * e0x;
    r = '0;
    if (den == 0) begin
      r.degen = 1'b1;
      return r;
    end
    u = round_quot(nu, den);
    v = round_quot(nv, den);
    t = longint'(tol);
    r.wc = clamp_weight(u);
    r.wb = clamp_weight(v);
    r.in_tri = (u >= -t) && (v >= -t) && (u + v <= (longint'(1) <<< FRAC) + t);
    return r;
  endfunction

  function automatic logic signed [CW-1:0] clip16(longint x);
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return x[CW-1:0];
  endfunction

  function automatic int rnd(int lo, int hi);
    return int'($urandom_range(hi - lo, 0)) + lo;
  endfunction

  function automatic tri_query_t random_query();
    tri_query_t q;
    longint ax, ay, e1x, e1y, e0x, e0y, s, t, k;
    int mode;
    mode = rnd(0, 9);
    ax = rnd(-8192, 8192);  ay = rnd(-8192, 8192);
    e1x = rnd(-4096, 4096); e1y = rnd(-4096, 4096);
    e0x = rnd(-4096, 4096); e0y = rnd(-4096, 4096);
    s = rnd(-1024, 5120);   t = rnd(-1024, 5120);
    case (mode)
      0, 1: begin
        q = {$urandom, $urandom, $urandom, $urandom};
        return q;
      end
      6: begin
        // on an edge or a corner
        case (rnd(0, 2))
          0: s = 0;
          1: t = 0;
          default: t = 4096 - s;
        endcase
        if (rnd(0, 1) == 1) s = s + rnd(-2, 2);
      end
      7: begin
        // collinear or coincident corners
        k = rnd(-3, 3);
        e0x = e1x * k;  e0y = e1y * k;
        if (rnd(0, 3) == 0) begin e1x = 0; e1y = 0; end
      end
      8: begin
        // tiny triangle, far point: saturated weights
        e1x = rnd(1, 3); e1y = rnd(-1, 1);
        e0x = rnd(-1, 1); e0y = rnd(1, 3);
        s = longint'(rnd(-32768, 32767)) * 4096;
        t = longint'(rnd(-32768, 32767)) * 4096;
      end
      9: begin
        ax = rnd(-8, 8); ay = rnd(-8, 8);
        e1x = rnd(-8, 8); e1y = rnd(-8, 8); e0x = rnd(-8, 8); e0y = rnd(-8, 8);
        s = rnd(-4096, 8192); t = rnd(-4096, 8192);
      end
      default: ;
    endcase
    q.ax = clip16(ax);         q.ay = clip16(ay);
    q.bx = clip16(ax + e1x);   q.by = clip16(ay + e1y);
    q.cx = clip16(ax + e0x);   q.cy = clip16(ay + e0y);
    q.px = clip16(ax + (s * e1x + t * e0x) / 4096);
    q.py = clip16(ay + (s * e1y + t * e0y) / 4096);
    return q;
  endfunction

  task automatic add_query(int px, int py, int ax, int ay, int bx, int by, int cx, int cy);
    tri_query_t q;
    q.px = px; q.py = py; q.ax = ax; q.ay = ay;
    q.bx = bx; q.by = by; q.cx = cx; q.cy = cy;
    pending_q = {pending_q, q};
  endtask

  task automatic present(tri_query_t q);
    in_valid      <= 1'b1;
    in_point_x    <= q.px;  in_point_y    <= q.py;
    in_corner_a_x <= q.ax;  in_corner_a_y <= q.ay;
    in_corner_b_x <= q.bx;  in_corner_b_y <= q.by;
    in_corner_c_x <= q.cx;  in_corner_c_y <= q.cy;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || expected_wts.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_tol(logic [TW-1:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tol_copy = val;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (in_valid && !in_stall) begin
      expected_wts = {expected_wts, barycentric_weights(cur_query, tol_copy)};
      gdraw = (quiet || rnd(0, 2) == 0) ? 0 : rnd(0, GAP_MAX);
      if (gdraw == 0 && pending_q.size() != 0 && !hold) begin
        cur_query = pending_q.pop_front();
        present(cur_query);
      end else begin
        in_valid <= 1'b0;
        in_gap   <= gdraw;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_q.size() != 0 && !hold) begin
        cur_query = pending_q.pop_front();
        present(cur_query);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait  <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_wts.size() == 0) begin
        $display("%0t: unexpected result wc=%0d wb=%0d in=%0b dg=%0b", $time,
                 out_weight_c, out_weight_b, out_inside_res, out_degenerate);
        errors++;
      end else begin
        bary_res_t e;
        e = expected_wts.pop_front();
        if (out_weight_c !== e.wc) begin
          $display("%0t: weight_c exp %0d got %0d", $time, e.wc, out_weight_c);
          errors++;
        end
        if (out_weight_b !== e.wb) begin
          $display("%0t: weight_b exp %0d got %0d", $time, e.wb, out_weight_b);
          errors++;
        end
        if (out_inside_res !== e.in_tri) begin
          $display("%0t: inside_res exp %0b got %0b", $time, e.in_tri, out_inside_res);
          errors++;
        end
        if (out_degenerate !== e.degen) begin
          $display("%0t: degenerate exp %0b got %0b", $time, e.degen, out_degenerate);
          errors++;
        end
      end
      sdraw = (quiet || rnd(0, 2) == 0) ? 0 : rnd(0, GAP_MAX);
      out_wait  <= sdraw;
      out_stall <= (sdraw > 0);
    end else if (out_wait > 0) begin
      out_wait  <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [TW-1:0] tols [0:6];
    tols = '{TW'(0), TW'(1023), TW'(1), TW'(512), TW'(0), TW'(0), TW'(0)};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset tolerance, directed
    add_query(0, 0, 0, 0, 0, 0, 0, 0);
    add_query(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_query(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_query(0, 0, -32768, -32768, 32767, -32768, -32768, 32767);
    add_query(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
    add_query(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768);
    add_query(0, 0, 0, 0, 4096, 0, 0, 4096);
    add_query(4096, 0, 0, 0, 4096, 0, 0, 4096);
    add_query(0, 4096, 0, 0, 4096, 0, 0, 4096);
    add_query(2048, 2048, 0, 0, 4096, 0, 0, 4096);
    add_query(1365, 1365, 0, 0, 4096, 0, 0, 4096);
    add_query(-1, 0, 0, 0, 4096, 0, 0, 4096);
    add_query(0, -1, 0, 0, 4096, 0, 0, 4096);
    add_query(2049, 2048, 0, 0, 4096, 0, 0, 4096);
    add_query(4096, 4096, 0, 0, 4096, 0, 0, 4096);
    add_query(5, 5, 0, 0, 100, 100, 200, 200);
    add_query(32767, -32768, 0, 0, 1, 0, 0, 1);
    add_query(-32768, 32767, 0, 0, 1, 0, 0, 1);
    add_query(1, 0, 0, 0, 2, 0, 0, 2);
    add_query(1, 1, 0, 0, 3, 0, 0, 3);
    add_query(-12, 7, 5, 5, 5, 5, 9, -3);
    for (int i = 0; i < 60; i++) pending_q = {pending_q, random_query()};

    for (int ph = 0; ph < 7; ph++) begin
      // wait until every result has drained, then hold the sender while the tolerance changes
      wait_idle();
      hold = 1'b1;
      if (ph >= 4) tols[ph] = TW'($urandom_range(1023, 0));
      write_tol(tols[ph]);
      quiet = (ph % 3 == 1);
      for (int i = 0; i < 230; i++) pending_q = {pending_q, random_query()};
      hold = 1'b0;
    end
    wait_idle();
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
